/* hdl/lauf_pkg.sv */
`default_nettype none

package lauf_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int MODE_W         = 4;
    localparam int DIV_W          = 6;
    localparam int OUT_BITS       = 2 * DIV_W;
    localparam int M_TDATA_W      = ((OUT_BITS + 7) / 8) * 8;

    // Laue class codes
    localparam logic [MODE_W-1:0] MODE_BAR1   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_2M     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_2MB    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MMM    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_4M     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_4MMM   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_BAR3H  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_BAR3R  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_BAR3MH = 4'd8;
    localparam logic [MODE_W-1:0] MODE_BAR3MR = 4'd9;
    localparam logic [MODE_W-1:0] MODE_6M     = 4'd10;
    localparam logic [MODE_W-1:0] MODE_6MMM   = 4'd11;
    localparam logic [MODE_W-1:0] MODE_M3     = 4'd12;
    localparam logic [MODE_W-1:0] MODE_M3M    = 4'd13;

    typedef logic [MODE_W-1:0] lauf_mode_t;
    typedef logic [DIV_W-1:0]  lauf_div_t;

    typedef struct packed {
        logic      keep;
        lauf_div_t site_divisor;
        lauf_div_t group_factor;
    } lauf_result_t;

    // Laue group multiplicity; unassigned codes behave as -1
    function automatic lauf_div_t group_factor_of(input lauf_mode_t mode);
        lauf_div_t g;
        begin
            case (mode)
                MODE_BAR1:   g = 6'd2;
                MODE_2M:     g = 6'd4;
                MODE_2MB:    g = 6'd2;
                MODE_MMM:    g = 6'd8;
                MODE_4M:     g = 6'd8;
                MODE_4MMM:   g = 6'd16;
                MODE_BAR3H:  g = 6'd6;
                MODE_BAR3R:  g = 6'd6;
                MODE_BAR3MH: g = 6'd12;
                MODE_BAR3MR: g = 6'd12;
                MODE_6M:     g = 6'd12;
                MODE_6MMM:   g = 6'd24;
                MODE_M3:     g = 6'd24;
                MODE_M3M:    g = 6'd48;
                default:     g = 6'd2;
            endcase
            return g;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/lauf_classify.sv */
`default_nettype none

module lauf_classify #(
    parameter int COORD_BITS = lauf_pkg::COORD_BITS_DEF
) (
    input  wire logic signed [COORD_BITS-1:0] coord_x,
    input  wire logic signed [COORD_BITS-1:0] coord_y,
    input  wire logic signed [COORD_BITS-1:0] coord_z,
    input  wire lauf_pkg::lauf_mode_t         mode,
    output lauf_pkg::lauf_result_t            res
);
    import lauf_pkg::*;

    localparam int EW = COORD_BITS + 2;

    // two guard bits so that 2*y and -y never overflow
    logic signed [EW-1:0] xe, ye, ze, y2, yn;

    assign xe = EW'(coord_x);
    assign ye = EW'(coord_y);
    assign ze = EW'(coord_z);
    assign y2 = ye <<< 1;
    assign yn = -ye;

    logic x_zero, y_zero, z_zero, z_neg, x_neg, y_neg;
    logic x_eq_y, y_eq_z, x_eq_2y, x_eq_ny;
    logic x_ge_y, y_ge_z, x_ge_2y, x_ge_ny;

    assign x_zero  = (xe == '0);
    assign y_zero  = (ye == '0);
    assign z_zero  = (ze == '0);
    assign x_neg   = xe[EW-1];
    assign y_neg   = ye[EW-1];
    assign z_neg   = ze[EW-1];
    assign x_eq_y  = (xe == ye);
    assign y_eq_z  = (ye == ze);
    assign x_eq_2y = (xe == y2);
    assign x_eq_ny = (xe == yn);
    assign x_ge_y  = (xe >= ye);
    assign y_ge_z  = (ye >= ze);
    assign x_ge_2y = (xe >= y2);
    assign x_ge_ny = (xe >= yn);

    always_comb
    begin
        logic      keep;
        lauf_div_t div;
        keep = 1'b1;
        div  = 6'd1;
        unique case (mode) inside
            MODE_2M, MODE_4M, MODE_6M:
            begin
                keep = !z_neg;
                if (z_zero) div = 6'd2;
            end
            MODE_MMM, MODE_M3:
            begin
                keep = !z_neg && !x_neg && !y_neg;
                if (z_zero) div = {div[DIV_W-2:0], 1'b0};
                if (x_zero) div = {div[DIV_W-2:0], 1'b0};
                if (y_zero) div = {div[DIV_W-2:0], 1'b0};
            end
            MODE_4MMM:
            begin
                keep = !z_neg && x_ge_y && !y_neg;
                if (z_zero) div = {div[DIV_W-2:0], 1'b0};
                if (y_zero) div = {div[DIV_W-2:0], 1'b0};
                if (x_eq_y) div = {div[DIV_W-2:0], 1'b0};
                if (x_zero) div = {div[DIV_W-2:0], 1'b0};
            end
            MODE_M3M:
            begin
                keep = !z_neg && y_ge_z && x_ge_y;
                if (x_zero)                         div = 6'd48;
                else if (y_zero && z_zero)          div = 6'd8;
                else if (x_eq_y && y_eq_z)          div = 6'd6;
                else if (x_eq_y && z_zero)          div = 6'd4;
                else if (z_zero || y_eq_z || x_eq_y) div = 6'd2;
            end
            MODE_6MMM:
            begin
                keep = !z_neg && !y_neg && x_ge_2y;
                if (x_zero && y_zero)        div = 6'd12;
                else if (y_zero || x_eq_2y)  div = 6'd2;
                if (z_zero) div = {div[DIV_W-2:0], 1'b0};
            end
            MODE_BAR3MH:
            begin
                keep = x_ge_ny && x_ge_2y;
                if (x_zero && y_zero)        div = 6'd6;
                else if (x_eq_ny || x_eq_2y) div = 6'd2;
            end
            MODE_BAR3MR:
            begin
                keep = x_ge_y && y_ge_z;
                if (x_eq_y && y_eq_z)      div = 6'd6;
                else if (x_eq_y || y_eq_z) div = 6'd2;
            end
            default:
            begin
                keep = 1'b1;
                div  = 6'd1;
            end
        endcase
        res.keep         = keep;
        res.site_divisor = keep ? div : 6'd1;
        res.group_factor = group_factor_of(mode);
    end

endmodule

`default_nettype wire

/* hdl/laue_asymmetric_unit_filter.sv */
`default_nettype none

// Channel   Dir  Payload (low bit up)                         Handshake
// s_axis    in   tdata: coord_x, coord_y, coord_z; tlast      tvalid/tready
// m_axis    out  tdata: site_divisor, group_factor;           tvalid/tready
//                tuser: keep; tlast
// cfg       in   cfg_wr_data: laue_mode                       cfg_wr_en
//
// The pipe is the input register, then the classify compares into the
// result register. One beat per cycle sustained; the only limit is the
// m_axis tready, propagated back through both register stages.
// rst_n (async, active low) empties both stages and sets laue_mode to -1.
// A stall holds the result register; the input register still fills, so
// two beats can be held before s_axis_tready drops.

module laue_asymmetric_unit_filter #(
    parameter int COORD_BITS = lauf_pkg::COORD_BITS_DEF,
    localparam int S_TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_wr_en,
    input  wire logic [lauf_pkg::MODE_W-1:0]        cfg_wr_data,   // laue_mode

    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]               s_axis_tdata,  // coord_x, coord_y, coord_z
    input  wire logic                               s_axis_tlast,

    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [lauf_pkg::M_TDATA_W-1:0]          m_axis_tdata,  // site_divisor, group_factor
    output logic                                    m_axis_tuser,  // keep
    output logic                                    m_axis_tlast
);
    import lauf_pkg::*;

    // config register
    lauf_mode_t mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_BAR1;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    // stage 1: input register
    logic                          v1_reg;
    logic signed [COORD_BITS-1:0]  x_reg, y_reg, z_reg;
    logic                          last1_reg;

    // stage 2: result register
    logic                          v2_reg;
    lauf_result_t                  res_reg;
    logic                          last2_reg;

    logic s2_ready, s1_ready;

    assign s2_ready      = !v2_reg || m_axis_tready;
    assign s1_ready      = !v1_reg || s2_ready;
    assign s_axis_tready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (s1_ready)
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s_axis_tvalid)
        begin
            x_reg     <= s_axis_tdata[COORD_BITS-1:0];
            y_reg     <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            z_reg     <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
            last1_reg <= s_axis_tlast;
        end
    end

    lauf_result_t res_next;

    lauf_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .coord_x (x_reg),
        .coord_y (y_reg),
        .coord_z (z_reg),
        .mode    (mode_reg),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (s2_ready)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && v1_reg)
        begin
            res_reg   <= res_next;
            last2_reg <= last1_reg;
        end
    end

    assign m_axis_tvalid = v2_reg;
    assign m_axis_tdata  = M_TDATA_W'({res_reg.group_factor, res_reg.site_divisor});
    assign m_axis_tuser  = res_reg.keep;
    assign m_axis_tlast  = last2_reg;

    // a rejected vector always carries divisor 1
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> res_reg.site_divisor == 6'd1)
        else $error("rejected beat with divisor other than 1");

    // divisor never zero on a valid beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> res_reg.site_divisor != '0)
        else $error("zero site divisor");

    // pass-through classes keep everything with divisor 1
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (mode_reg == MODE_BAR1 || mode_reg == MODE_2MB ||
                          mode_reg == MODE_BAR3H || mode_reg == MODE_BAR3R)
        |-> m_axis_tuser && res_reg.site_divisor == 6'd1)
        else $error("pass-through class dropped or divided a vector");

    // backpressure only when both stages are full
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> v1_reg && v2_reg && !m_axis_tready)
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire

/* dv/tb_laue_asymmetric_unit_filter.sv */
`timescale 1ns / 100ps

// Self-checking bench for the Laue asymmetric-unit filter.
// Vectors stream in on s_axis, every accepted beat is classified by a local
// model at the moment of acceptance, and each m_axis beat is checked against
// the oldest outstanding verdict. The class register is only rewritten with
// the pipe empty, so the local copy of the class is always the one in use.
module tb_laue_asymmetric_unit_filter;

    import lauf_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int S_W         = ((3 * CB + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 120;

    // codes past the last defined class; they must act like -1
    localparam lauf_mode_t MODE_SPARE_LO = 4'd14;
    localparam lauf_mode_t MODE_SPARE_HI = 4'd15;

    typedef logic signed [CB-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(CB-1){1'b0}}};

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } vec_t;

    typedef struct packed {
        lauf_result_t res;
        logic         last;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_wr_en = 1'b0;
    logic [MODE_W-1:0]    cfg_wr_data = '0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_W-1:0]       s_axis_tdata = '0;    // coord_x, coord_y, coord_z
    logic                 s_axis_tlast = 1'b0;

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // site_divisor, group_factor
    logic                 m_axis_tuser;         // keep
    logic                 m_axis_tlast;

    // class currently loaded in the block, tracked by the bench
    lauf_mode_t cur_mode = MODE_BAR1;

    vec_t     vector_q[$];      // vectors waiting for the driver
    verdict_t verdict_q[$];     // classifications still owed by the block

    int  n_queued = 0;
    int  n_accepted = 0;
    int  err_cnt = 0;
    int  cycle_cnt = 0;

    // idle control: calm turns off random idling, want_hold asks the sink for
    // one long back-pressure stretch
    logic calm = 1'b0;
    logic want_hold = 1'b0;

    laue_asymmetric_unit_filter #(
        .COORD_BITS(CB)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Classifier: asymmetric-unit membership, special-position divisor and
    // group multiplicity for one vector under one Laue class. Compares run
    // on 64-bit values so the 2*y terms cannot wrap.
    // ------------------------------------------------------------------
    function automatic lauf_result_t classify_vector(input lauf_mode_t mode,
                                                     input coord_t cx,
                                                     input coord_t cy,
                                                     input coord_t cz);
        longint       x;
        longint       y;
        longint       z;
        logic         kept;
        int           div;
        int           mult;
        lauf_result_t r;
        begin
            x = cx;
            y = cy;
            z = cz;
            kept = 1'b1;
            div = 1;
            case (mode)
                MODE_2M, MODE_4M, MODE_6M:
                begin
                    if (z < 0)
                        kept = 1'b0;
                    else if (z == 0)
                        div = 2;
                end
                MODE_MMM, MODE_M3:
                begin
                    if (z < 0 || x < 0 || y < 0)
                        kept = 1'b0;
                    else
                    begin
                        if (z == 0) div *= 2;
                        if (x == 0) div *= 2;
                        if (y == 0) div *= 2;
                    end
                end
                MODE_4MMM:
                begin
                    if (!(z >= 0 && x >= y && y >= 0))
                        kept = 1'b0;
                    else
                    begin
                        if (z == 0) div *= 2;
                        if (y == 0) div *= 2;
                        if (x == y) div *= 2;
                        if (x == 0) div *= 2;
                    end
                end
                MODE_M3M:
                begin
                    if (!(z >= 0 && y >= z && x >= y))
                        kept = 1'b0;
                    else if (x == 0)
                        div = 48;
                    else if (y == 0 && z == 0)
                        div = 8;
                    else if (x == y && x == z)
                        div = 6;
                    else if (x == y && z == 0)
                        div = 4;
                    else if (z == 0 || y == z || x == y)
                        div = 2;
                end
                MODE_6MMM:
                begin
                    if (!(z >= 0 && y >= 0 && x >= 2 * y))
                        kept = 1'b0;
                    else
                    begin
                        if (x == 0 && y == 0)
                            div = 12;
                        else if (y == 0 || x == 2 * y)
                            div = 2;
                        if (z == 0) div *= 2;
                    end
                end
                MODE_BAR3MH:
                begin
                    if (!(x >= -y && x >= 2 * y))
                        kept = 1'b0;
                    else if (x == 0 && y == 0)
                        div = 6;
                    else if (x == -y || x == 2 * y)
                        div = 2;
                end
                MODE_BAR3MR:
                begin
                    if (!(x >= y && y >= z))
                        kept = 1'b0;
                    else if (x == y && y == z)
                        div = 6;
                    else if (x == y || y == z)
                        div = 2;
                end
                default: ;  // -1, 2/mb, -3H, -3R and spare codes keep all
            endcase

            case (mode)
                MODE_2M:                         mult = 4;
                MODE_MMM, MODE_4M:               mult = 8;
                MODE_4MMM:                       mult = 16;
                MODE_BAR3H, MODE_BAR3R:          mult = 6;
                MODE_BAR3MH, MODE_BAR3MR,
                MODE_6M:                         mult = 12;
                MODE_6MMM, MODE_M3:              mult = 24;
                MODE_M3M:                        mult = 48;
                default:                         mult = 2;
            endcase

            r.keep         = kept;
            r.site_divisor = kept ? lauf_div_t'(div) : lauf_div_t'(1);
            r.group_factor = lauf_div_t'(mult);
            return r;
        end
    endfunction

    // Coordinate palette: zeros, +/- base and twice base make the equality
    // and boundary cases (x == y, x == 2y, x == -y ...) common.
    function automatic coord_t pick_coord(input coord_t b);
        begin
            case ($urandom_range(0, 9))
                0, 1:    return '0;
                2, 3:    return b;
                4:       return -b;
                5:       return coord_t'(b * 2);
                6:       return coord_t'(-(b * 2));
                7:       return COORD_MAX;
                8:       return COORD_MIN;
                default: return coord_t'($urandom);
            endcase
        end
    endfunction

    task automatic make_vector(output vec_t v);
        coord_t b;
        coord_t t;
        begin
            // mostly small bases, some near the top so 2*base still fits
            if ($urandom_range(0, 2) != 0)
                b = coord_t'($urandom_range(1, 40));
            else
                b = coord_t'($urandom_range(1, 4194303));
            v.x = pick_coord(b);
            v.y = pick_coord(b);
            v.z = pick_coord(b);
            // half the time order them x >= y >= z so the ordered classes
            // see plenty of vectors inside their unit
            if ($urandom_range(0, 1) != 0)
            begin
                if (v.x < v.y)
                begin
                    t = v.x;
                    v.x = v.y;
                    v.y = t;
                end
                if (v.y < v.z)
                begin
                    t = v.y;
                    v.y = v.z;
                    v.z = t;
                end
                if (v.x < v.y)
                begin
                    t = v.x;
                    v.x = v.y;
                    v.y = t;
                end
            end
            v.last = ($urandom_range(0, 4) == 0);
        end
    endtask

    task automatic queue_vec(input coord_t x, input coord_t y, input coord_t z,
                             input logic last);
        vec_t v;
        begin
            v.x = x;
            v.y = y;
            v.z = z;
            v.last = last;
            vector_q.insert(vector_q.size(), v);
            n_queued++;
        end
    endtask

    task automatic queue_random(input int count);
        vec_t v;
        begin
            repeat (count)
            begin
                make_vector(v);
                vector_q.insert(vector_q.size(), v);
                n_queued++;
            end
        end
    endtask

    // sender stays quiet until every beat is through and answered
    task automatic wait_drained();
        begin
            @(negedge clk);
            while (n_accepted != n_queued || verdict_q.size() != 0)
                @(negedge clk);
            // two-stage pipe; extra idle margin before touching the register
            repeat (4) @(negedge clk);
        end
    endtask

    task automatic set_mode(input lauf_mode_t m);
        begin
            @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= m;
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            cur_mode = m;
            @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Source: classifies the beat that leaves at this edge, then puts the
    // next pending vector on the bus or idles for a short burst.
    // ------------------------------------------------------------------
    int   src_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        vec_t     nxt;
        verdict_t vd;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                vd.res  = classify_vector(cur_mode,
                                          coord_t'(s_axis_tdata[CB-1:0]),
                                          coord_t'(s_axis_tdata[2*CB-1:CB]),
                                          coord_t'(s_axis_tdata[3*CB-1:2*CB]));
                vd.last = s_axis_tlast;
                verdict_q.insert(verdict_q.size(), vd);
                n_accepted++;
            end

            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (vector_q.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    src_gap = $urandom_range(0, 6);
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    nxt = vector_q.pop_front();
                    s_axis_tdata  <= S_W'({nxt.z, nxt.y, nxt.x});
                    s_axis_tlast  <= nxt.last;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long sink hold-off: one stretch on request, timed here so the sink
    // only sees a level.
    // ------------------------------------------------------------------
    int   hold_cnt = 0;
    logic hold_on = 1'b0;
    logic hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (want_hold && !hold_done)
        begin
            // long enough to fill both stages and back up the source
            hold_done <= 1'b1;
            hold_on   <= 1'b1;
            hold_cnt  <= 0;
        end
        else if (hold_on)
        begin
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_on <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sink: checks each result beat against the oldest verdict and drives
    // tready with random stall bursts plus the long hold-off.
    // ------------------------------------------------------------------
    int   sink_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        verdict_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.res.keep         = m_axis_tuser;
                got.res.site_divisor = m_axis_tdata[DIV_W-1:0];
                got.res.group_factor = m_axis_tdata[2*DIV_W-1:DIV_W];
                got.last             = m_axis_tlast;
                if (verdict_q.size() == 0)
                begin
                    if (err_cnt < MAX_REPORTS)
                        $display("ERROR: unexpected beat keep=%0d div=%0d grp=%0d last=%0d",
                                 got.res.keep, got.res.site_divisor,
                                 got.res.group_factor, got.last);
                    err_cnt++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got.res.keep !== want.res.keep
                        || got.res.site_divisor !== want.res.site_divisor
                        || got.res.group_factor !== want.res.group_factor
                        || got.last !== want.last)
                    begin
                        if (err_cnt < MAX_REPORTS)
                        begin
                            $display("ERROR: mode %0d exp keep=%0d div=%0d grp=%0d last=%0d,",
                                     cur_mode, want.res.keep, want.res.site_divisor,
                                     want.res.group_factor, want.last);
                            $display("       got keep=%0d div=%0d grp=%0d last=%0d",
                                     got.res.keep, got.res.site_divisor,
                                     got.res.group_factor, got.last);
                        end
                        err_cnt++;
                    end
                end
            end

            if (hold_on)
                m_axis_tready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                sink_gap = $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan
    // ------------------------------------------------------------------
    initial
    begin
        int p;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset class is -1: field extremes all pass with divisor 1
        queue_vec(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        queue_vec(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_vec('0, '0, '0, 1'b1);
        queue_random(40);

        // walk every code 1..15, then back to 0
        for (p = 1; p <= 16; p++)
        begin
            wait_drained();
            set_mode(lauf_mode_t'(p % 16));
            case (cur_mode)
                MODE_M3M:
                begin
                    queue_vec('0, '0, '0, 1'b0);        // origin, 48
                    queue_vec(5, '0, '0, 1'b0);         // axis, 8
                    queue_vec(5, 5, 5, 1'b0);           // body diagonal, 6
                    queue_vec(5, 5, '0, 1'b0);          // face diagonal, 4
                    queue_vec(7, 3, 3, 1'b0);           // mirror, 2
                    queue_vec(7, 5, 3, 1'b0);           // general
                    queue_vec(3, 5, 1, 1'b1);           // outside
                end
                MODE_6MMM:
                begin
                    queue_vec('0, '0, 7, 1'b0);         // six-fold axis
                    queue_vec('0, '0, '0, 1'b0);        // origin
                    queue_vec(6, 3, '0, 1'b0);          // x == 2y on the plane
                    queue_vec(24'sd8388606, 24'sd4194303, 1, 1'b0);
                    queue_vec(5, -1, '0, 1'b1);         // outside
                end
                MODE_BAR3MH:
                begin
                    queue_vec('0, '0, '0, 1'b0);
                    queue_vec(4, -4, COORD_MIN, 1'b0);  // x == -y
                    queue_vec(6, 3, '0, 1'b0);          // x == 2y
                    queue_vec(-1, '0, '0, 1'b1);        // outside
                end
                MODE_BAR3MR:
                begin
                    queue_vec(2, 2, 2, 1'b0);
                    queue_vec(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
                end
                MODE_4MMM:
                    queue_vec('0, '0, '0, 1'b1);        // every mirror at once
                default: ;
            endcase
            // one phase runs against a long sink stall
            if (p == 6)
                want_hold <= 1'b1;
            queue_random(60);
        end

        // random classes, idling off for the tail
        for (p = 0; p < 8; p++)
        begin
            wait_drained();
            set_mode(lauf_mode_t'($urandom_range(0, 15)));
            if (p == 6)
                calm <= 1'b1;
            queue_random(70);
        end

        // spare codes last, top one first, no idling
        wait_drained();
        set_mode(MODE_SPARE_HI);
        queue_random(20);
        wait_drained();
        set_mode(MODE_SPARE_LO);
        queue_random(20);

        wait_drained();
        repeat (10) @(negedge clk);
        if (verdict_q.size() != 0)
            err_cnt += verdict_q.size();

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* laue_asymmetric_unit_filter.f */
hdl/lauf_pkg.sv
hdl/lauf_classify.sv
hdl/laue_asymmetric_unit_filter.sv
dv/tb_laue_asymmetric_unit_filter.sv
